// ===== rtl/core/sllm_pkg.sv =====
// Shared types and codes of the slot linked list manager.
// No dependencies; imported by every module of the block.
package sllm_pkg;

  // Request kind carried on in_tuser.
  typedef enum logic [1:0] {
    FN_HEAD  = 2'd0,
    FN_AFTER = 2'd1,
    FN_TAIL  = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // Outcome carried on out_tuser.
  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_BADPOS = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_LOOK,
    SQ_LINK
  } seq_state_t;

  // Fixed port-side field widths.
  localparam int unsigned POS_W   = 6;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LINK_OW = 7;

  typedef struct packed {
    func_t               func;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   payload;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    slot;
    logic [DATA_W-1:0]   entry_payload;
    logic [LINK_OW-1:0]  entry_prev;
    logic [LINK_OW-1:0]  entry_next;
    logic                entry_in_use;
    logic [LINK_OW-1:0]  element_count;
    logic [LINK_OW-1:0]  head_slot;
    logic [LINK_OW-1:0]  tail_slot;
  } result_t;

  // Strobes from the sequencer to the slot store.
  typedef struct packed {
    logic rd_en;
    logic pay_we;
    logic next_we;
    logic prev_we;
  } mem_ctl_t;

endpackage

// ===== rtl/core/sllm_store.sv =====
// Slot store: payload, next-link and prev-link memories, one write and one
// registered read per memory per cycle. Depends on sllm_pkg.
module sllm_store #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned IW           = 6,
  parameter int unsigned LW           = 7
) (
  input  logic                    clk,
  input  sllm_pkg::mem_ctl_t      mem,
  input  logic [IW-1:0]           rd_addr,
  input  logic [IW-1:0]           pay_waddr,
  input  logic [PAYLOAD_BITS-1:0] pay_wdata,
  input  logic [IW-1:0]           next_waddr,
  input  logic [LW-1:0]           next_wdata,
  input  logic [IW-1:0]           prev_waddr,
  input  logic [LW-1:0]           prev_wdata,
  output logic [PAYLOAD_BITS-1:0] rd_pay,
  output logic [LW-1:0]           rd_next,
  output logic [LW-1:0]           rd_prev
);
  import sllm_pkg::*;

  logic [PAYLOAD_BITS-1:0] pay_mem  [SLOTS];
  logic [LW-1:0]           next_mem [SLOTS];
  logic [LW-1:0]           prev_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (mem.pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (mem.rd_en) begin
      rd_pay <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (mem.rd_en) begin
      rd_next <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (mem.rd_en) begin
      rd_prev <= prev_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sllm_ctrl.sv =====
// Sequencer of the slot linked list manager: head, tail and count registers,
// insert/read decode, link write-back and the result register. Uses sllm_pkg.
module sllm_ctrl #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned IW           = 6,
  parameter int unsigned LW           = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sllm_pkg::item_t         item,
  output sllm_pkg::mem_ctl_t      mem,
  output logic [IW-1:0]           rd_addr,
  output logic [IW-1:0]           pay_waddr,
  output logic [PAYLOAD_BITS-1:0] pay_wdata,
  output logic [IW-1:0]           next_waddr,
  output logic [LW-1:0]           next_wdata,
  output logic [IW-1:0]           prev_waddr,
  output logic [LW-1:0]           prev_wdata,
  input  logic [PAYLOAD_BITS-1:0] rd_pay,
  input  logic [LW-1:0]           rd_next,
  input  logic [LW-1:0]           rd_prev,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sllm_pkg::result_t       res
);
  import sllm_pkg::*;

  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  seq_state_t state_r, state_nxt;

  func_t                   func_r;
  logic [POS_W-1:0]        pos_r;
  logic [PAYLOAD_BITS-1:0] data_r;
  logic [LW-1:0]           head_r, head_nxt;
  logic [LW-1:0]           tail_r, tail_nxt;
  logic [LW-1:0]           count_r, count_nxt;
  logic                    out_valid_r;
  result_t                 res_r, res_nxt;

  // second-pass link writes, latched in LOOK
  logic          lnk_next_we_r, lnk_next_we_nxt;
  logic [IW-1:0] lnk_next_addr_r, lnk_next_addr_nxt;
  logic          lnk_prev_we_r, lnk_prev_we_nxt;
  logic [IW-1:0] lnk_prev_addr_r, lnk_prev_addr_nxt;
  logic [LW-1:0] lnk_fresh_r;

  logic          accept, fire;
  logic          full, pos_in_use, at_head, do_insert;
  logic [LW-1:0] anchor, fresh, new_prev, new_next;

  assign accept = in_ready && in_valid;
  assign fire   = (state_r == SQ_LOOK) && (!out_valid_r || out_ready);

  // decode of the item waiting in LOOK
  always_comb begin
    full       = (count_r == NONE);
    pos_in_use = (32'(pos_r) < 32'(count_r));
    fresh      = count_r;
    at_head    = (func_r == FN_HEAD) ||
                 ((func_r == FN_TAIL) && ((head_r == NONE) || (tail_r == NONE)));
    anchor     = (func_r == FN_AFTER) ? LW'(pos_r) : tail_r;
    do_insert  = (func_r != FN_READ) && !full &&
                 !((func_r == FN_AFTER) && !pos_in_use);
    new_prev   = at_head ? NONE : anchor;
    new_next   = at_head ? head_r : rd_next;

    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    lnk_next_we_nxt   = 1'b0;
    lnk_next_addr_nxt = IW'(anchor);
    lnk_prev_we_nxt   = 1'b0;
    lnk_prev_addr_nxt = IW'(new_next);
    if (do_insert) begin
      count_nxt = LW'(count_r + LW'(1));
      if (at_head) begin
        head_nxt        = fresh;
        lnk_prev_we_nxt = (head_r < NONE);
        if (!(head_r < NONE)) begin
          tail_nxt = fresh;
        end
      end else begin
        lnk_next_we_nxt = 1'b1;
        lnk_prev_we_nxt = (rd_next < NONE);
        if (!(rd_next < NONE)) begin
          tail_nxt = fresh;
        end
      end
    end

    res_nxt.status        = STS_OK;
    res_nxt.slot          = pos_r;
    res_nxt.entry_payload = '0;
    res_nxt.entry_prev    = LINK_OW'(NONE);
    res_nxt.entry_next    = LINK_OW'(NONE);
    res_nxt.entry_in_use  = 1'b0;
    res_nxt.element_count = LINK_OW'(count_nxt);
    res_nxt.head_slot     = LINK_OW'(head_nxt);
    res_nxt.tail_slot     = LINK_OW'(tail_nxt);
    if (func_r == FN_READ) begin
      if (pos_in_use) begin
        res_nxt.entry_payload = DATA_W'(rd_pay);
        res_nxt.entry_prev    = LINK_OW'(rd_prev);
        res_nxt.entry_next    = LINK_OW'(rd_next);
        res_nxt.entry_in_use  = 1'b1;
      end else begin
        res_nxt.status = STS_BADPOS;
      end
    end else if (full) begin
      res_nxt.status = STS_FULL;
      res_nxt.slot   = '0;
    end else if (!do_insert) begin
      res_nxt.status = STS_BADPOS;
    end else begin
      res_nxt.slot          = POS_W'(fresh);
      res_nxt.entry_payload = DATA_W'(data_r);
      res_nxt.entry_prev    = LINK_OW'(new_prev);
      res_nxt.entry_next    = LINK_OW'(new_next);
      res_nxt.entry_in_use  = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (accept) begin
          state_nxt = SQ_LOOK;
        end
      end
      SQ_LOOK: begin
        if (fire) begin
          state_nxt = do_insert ? SQ_LINK : SQ_IDLE;
        end
      end
      SQ_LINK: state_nxt = SQ_IDLE;
      default: state_nxt = SQ_IDLE;
    endcase
  end

  // outputs: handshake and memory strobes
  always_comb begin
    in_ready   = 1'b0;
    mem        = '0;
    rd_addr    = (item.func == FN_TAIL) ? IW'(tail_r) : IW'(item.position);
    pay_waddr  = IW'(fresh);
    pay_wdata  = data_r;
    next_waddr = IW'(fresh);
    next_wdata = new_next;
    prev_waddr = IW'(fresh);
    prev_wdata = new_prev;
    unique case (state_r)
      SQ_IDLE: begin
        in_ready  = 1'b1;
        mem.rd_en = in_valid;
      end
      SQ_LOOK: begin
        mem.pay_we  = fire && do_insert;
        mem.next_we = fire && do_insert;
        mem.prev_we = fire && do_insert;
      end
      SQ_LINK: begin
        mem.next_we = lnk_next_we_r;
        mem.prev_we = lnk_prev_we_r;
        next_waddr  = lnk_next_addr_r;
        next_wdata  = lnk_fresh_r;
        prev_waddr  = lnk_prev_addr_r;
        prev_wdata  = lnk_fresh_r;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SQ_IDLE;
      head_r        <= NONE;
      tail_r        <= NONE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      lnk_next_we_r <= 1'b0;
      lnk_prev_we_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        head_r        <= head_nxt;
        tail_r        <= tail_nxt;
        count_r       <= count_nxt;
        lnk_next_we_r <= lnk_next_we_nxt;
        lnk_prev_we_r <= lnk_prev_we_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= item.func;
      pos_r  <= item.position;
      data_r <= PAYLOAD_BITS'(item.payload);
    end
    if (fire) begin
      res_r           <= res_nxt;
      lnk_next_addr_r <= lnk_next_addr_nxt;
      lnk_prev_addr_r <= lnk_prev_addr_nxt;
      lnk_fresh_r     <= fresh;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/slot_linked_list_manager.sv =====
// Top level of the slot linked list manager: stream ports, sequencer and
// slot store. Depends on sllm_pkg, sllm_ctrl and sllm_store.

// A doubly linked list of payload words held in SLOTS slots. Each input word
// (func on in_tuser) inserts at the head, after a slot, or at the tail, or
// reads one slot; every word gives exactly one result word with the status
// on out_tuser. Slots are never freed, so an insert always takes slot number
// "count" and a slot is in use exactly when it is below the count: no valid
// bits and no clearing pass are needed, and the block takes words straight
// out of reset. One word is handled at a time. A read or a rejected insert
// goes through IDLE (issue the memory read) and LOOK (decide and load the
// result); a good insert goes on to LINK, because the new entry and the
// neighbour's back-link both land in the prev-link memory, which has a single
// write port, so neighbour links go back in LINK. The result register lets
// the next word be taken while the last result still waits on out_tready.
module slot_linked_list_manager #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // func
  input  logic [39:0] in_tdata,   // position[5:0], payload[37:6], zero pad[39:38]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status
  // slot[5:0], entry_payload[37:6], entry_prev[44:38], entry_next[51:45],
  // entry_in_use[52], element_count[59:53], head_slot[66:60],
  // tail_slot[73:67], zero pad[79:74]
  output logic [79:0] out_tdata
);
  import sllm_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = $clog2(SLOTS + 1);

  item_t                   item;
  result_t                 res;
  mem_ctl_t                mem;
  logic [IW-1:0]           rd_addr, pay_waddr, next_waddr, prev_waddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, rd_pay;
  logic [LW-1:0]           next_wdata, prev_wdata, rd_next, rd_prev;

  assign item.func     = func_t'(in_tuser);
  assign item.position = in_tdata[5:0];
  assign item.payload  = in_tdata[37:6];

  sllm_ctrl #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IW           (IW),
    .LW           (LW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .item       (item),
    .mem        (mem),
    .rd_addr    (rd_addr),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .rd_pay     (rd_pay),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .res        (res)
  );

  sllm_store #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IW           (IW),
    .LW           (LW)
  ) u_store (
    .clk        (clk),
    .mem        (mem),
    .rd_addr    (rd_addr),
    .pay_waddr  (pay_waddr),
    .pay_wdata  (pay_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .rd_pay     (rd_pay),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev)
  );

  assign out_tuser = res.status;
  assign out_tdata = {6'd0, res.tail_slot, res.head_slot, res.element_count,
                      res.entry_in_use, res.entry_next, res.entry_prev,
                      res.entry_payload, res.slot};

  // one word in flight: nothing is taken the cycle after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("word accepted while previous one still in progress");

  // memory reads are only issued while no write-back is under way
  a_no_rd_during_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mem.rd_en |-> !(mem.pay_we || mem.next_we || mem.prev_we))
    else $error("slot store read overlaps a write");

  // an empty list reports no head and no tail
  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res.element_count == '0)) |->
      ((res.head_slot == LINK_OW'(SLOTS)) && (res.tail_slot == LINK_OW'(SLOTS))))
    else $error("empty list with a head or tail slot");

  // a full answer only when the count has reached the slot total
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res.status == STS_FULL)) |->
      (res.element_count == LINK_OW'(SLOTS)))
    else $error("store full reported below capacity");

endmodule
